// ----- rtl/core/cvc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the corner vote clusterer.
// No dependencies; all modules of the block but cvc_ram import this package.
package cvc_pkg;

    // Field widths
    localparam int COORD_W   = 10;
    localparam int LSIG_W    = 9;
    localparam int LINE_W    = 6;
    localparam int SLOT_W    = 3;
    localparam int COUNT_W   = 4;
    localparam int SIG_W     = 18;
    localparam int COLS_W    = 7;
    // hline * columns + vline stays below 8192
    localparam int ADDR_W    = 13;

    localparam int SLOTS_PER_CLUSTER = 8;
    localparam int MAX_CORNERS_DEF   = 4096;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [COLS_W-1:0] MESH_COLUMNS_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_BAD     = 3'd1,
        ST_APPEND  = 3'd2,
        ST_REPLACE = 3'd3,
        ST_DROPNEW = 3'd4,
        ST_READ    = 3'd5,
        ST_RANGE   = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_BAD,
        CMD_RANGE,
        CMD_READ,
        CMD_VOTE
    } cmd_op_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } back_state_t;

    typedef struct packed {
        logic                kind;
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
        logic [LSIG_W-1:0]   vertical_signal;
        logic [LSIG_W-1:0]   horizontal_signal;
        logic [LINE_W-1:0]   vertical_line;
        logic [LINE_W-1:0]   horizontal_line;
        logic                bad_line;
        logic [SLOT_W-1:0]   read_slot;
    } in_word_t;

    typedef struct packed {
        status_t             status;
        logic [COUNT_W-1:0]  cluster_count;
        logic [SIG_W-1:0]    dropped_signal;
        logic [COORD_W-1:0]  voter_x;
        logic [COORD_W-1:0]  voter_y;
        logic [SIG_W-1:0]    voter_signal;
    } out_word_t;

    typedef struct packed {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [SIG_W-1:0]    signal;
    } voter_t;

    typedef voter_t [SLOTS_PER_CLUSTER-1:0] cluster_t;

    // Classified item handed from the front to the back
    typedef struct packed {
        cmd_op_t             op;
        logic [ADDR_W-1:0]   idx;
        voter_t              voter;
        logic [SLOT_W-1:0]   slot;
    } cmd_t;

endpackage

// ----- rtl/core/corner_vote_clusterer.sv -----
`timescale 1ns / 1ps
// Corner vote clusterer: top level joining front, queue and back parts.
// Depends on cvc_pkg, cvc_front, cvc_queue, cvc_back and cvc_ram.
//
// Usage:
//   in_valid/in_ready/in_word carry one vote or read word. A vote with both
//   line signals, a nonzero pixel and no bad_line is weighted by their
//   product and added to cluster hline * mesh_columns + vline if in range.
//   out_valid/out_ready/out_word return exactly one result word per input.
//   cfg_valid/cfg_ready/cfg_data write mesh_columns; write only while idle.
// Back part:
//   A vote or read passes BK_IDLE, which issues the registered read of the
//   count and cluster RAMs, then BK_EXEC, which does the update and
//   write-back through the write ports of the same RAMs once the output
//   register is free; the back part takes no new word meanwhile. A word
//   that skips the tables goes from BK_IDLE into the output register.
// Reset:
//   mesh_columns returns to 64 and the count table is swept to zero, one
//   entry per cycle; in_ready stays low until the sweep ends.
//   The voter table is not cleared.
// Stall:
//   The result waits in the output register while out_ready is low; a
//   two-entry queue keeps accepting words until it fills.
module corner_vote_clusterer import cvc_pkg::*; #(
    parameter int MAX_CORNERS = MAX_CORNERS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_word_t          in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output out_word_t         out_word,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [COLS_W-1:0] cfg_data
);

    logic q_full;
    logic q_push;
    cmd_t q_push_cmd;
    logic q_pop;
    logic q_valid;
    cmd_t q_head;
    logic clearing;

    // Accept and classify words
    cvc_front #(
        .MAX_CORNERS (MAX_CORNERS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .clearing  (clearing),
        .q_push    (q_push),
        .q_cmd     (q_push_cmd)
    );

    // Hold classified words between the two parts
    cvc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    // Carry out table updates and reads
    cvc_back #(
        .MAX_CORNERS (MAX_CORNERS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    // No input word is taken during the clearing sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_ready)
        else $error("input accepted during count clearing");

    // A cluster never reports more voters than it has slots
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.cluster_count <= COUNT_W'(SLOTS_PER_CLUSTER)))
        else $error("cluster count above slot count");

    // Read-back fields are zero outside read results
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_word.status != ST_READ))
            |-> ((out_word.voter_signal == '0) && (out_word.voter_x == '0)
                 && (out_word.voter_y == '0)))
        else $error("voter fields set outside a read");

    // An appended vote always leaves a nonempty cluster
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_word.status == ST_APPEND)) |-> (out_word.cluster_count != '0))
        else $error("append reported with empty cluster");

endmodule

// ----- rtl/core/cvc_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/cvc_front.sv -----
`timescale 1ns / 1ps
// Front part: input word acceptance, mesh_columns register, vote weight,
// cluster address and classification. Depends on cvc_pkg.
module cvc_front import cvc_pkg::*; #(
    parameter int MAX_CORNERS = MAX_CORNERS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_word_t          in_word,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [COLS_W-1:0] cfg_data,
    input  logic              q_full,
    input  logic              clearing,
    output logic              q_push,
    output cmd_t              q_cmd
);

    logic [COLS_W-1:0]   mesh_columns_reg;
    logic [ADDR_W-1:0]   row_base;
    logic [ADDR_W-1:0]   addr;
    logic                range_fault;
    logic                no_signal;
    logic [SIG_W-1:0]    weight;

    // Configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mesh_columns_reg <= MESH_COLUMNS_RESET;
        end
        else if (cfg_valid)
        begin
            mesh_columns_reg <= cfg_data;
        end
    end

    // Accept while the queue has room and the count table is not being cleared
    assign in_ready = !q_full && !clearing;
    assign q_push   = in_valid && in_ready;

    // Cluster address and range check
    assign row_base    = ADDR_W'(in_word.horizontal_line) * ADDR_W'(mesh_columns_reg);
    assign addr        = row_base + ADDR_W'(in_word.vertical_line);
    assign range_fault = (COLS_W'(in_word.vertical_line) >= mesh_columns_reg)
                      || (32'(addr) >= 32'(MAX_CORNERS));

    // Vote weight and empty-vote test
    assign weight    = SIG_W'(in_word.vertical_signal) * SIG_W'(in_word.horizontal_signal);
    assign no_signal = (in_word.vertical_signal == '0) || (in_word.horizontal_signal == '0)
                    || ((in_word.pixel_x == '0) && (in_word.pixel_y == '0));

    // Classify the word
    always_comb
    begin
        q_cmd.idx          = addr;
        q_cmd.voter.x      = in_word.pixel_x;
        q_cmd.voter.y      = in_word.pixel_y;
        q_cmd.voter.signal = weight;
        q_cmd.slot         = in_word.read_slot;
        if (in_word.kind)
        begin
            q_cmd.op = range_fault ? CMD_RANGE : CMD_READ;
        end
        else if (no_signal)
        begin
            q_cmd.op = CMD_NONE;
        end
        else if (in_word.bad_line)
        begin
            q_cmd.op = CMD_BAD;
        end
        else if (range_fault)
        begin
            q_cmd.op = CMD_RANGE;
        end
        else
        begin
            q_cmd.op = CMD_VOTE;
        end
    end

endmodule

// ----- rtl/core/cvc_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between the front and the back part.
// Depends on cvc_pkg.
module cvc_queue import cvc_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic              do_push;
    logic              do_pop;

    assign full       = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/cvc_back.sv -----
`timescale 1ns / 1ps
// Back part: count table clearing, cluster read-modify-write, read-back and
// the output register. Depends on cvc_pkg and cvc_ram.
module cvc_back import cvc_pkg::*; #(
    parameter int MAX_CORNERS = MAX_CORNERS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  cmd_t      q_head,
    output logic      q_pop,
    output logic      clearing,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    localparam int IDX_W = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1;
    localparam int NV    = SLOTS_PER_CLUSTER + 1;

    back_state_t          state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [IDX_W-1:0]     clr_addr_reg, clr_addr_next;
    logic                 out_valid_reg, out_valid_next;
    out_word_t            out_word_reg, out_word_next;

    logic                 out_free;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 cnt_wr_en;
    logic [IDX_W-1:0]     cnt_wr_addr;
    logic [COUNT_W-1:0]   cnt_wr_data;
    logic [COUNT_W-1:0]   cnt_rdata;
    logic                 clu_wr_en;
    cluster_t             clu_rdata;
    cluster_t             clu_merged;
    cluster_t             clu_appended;
    voter_t               carry;
    logic                 swapped;
    logic                 has_room;
    voter_t               read_voter;
    voter_t               cand [NV];
    logic [NV-1:0]        beats [NV];
    logic [NV-1:0]        lead [NV];
    voter_t               prefix_min [NV];

    // Count table, cleared by a sweep after reset
    cvc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (MAX_CORNERS)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (cnt_rdata)
    );

    // Voter table, one cluster per word
    cvc_ram #(
        .WIDTH ($bits(cluster_t)),
        .DEPTH (MAX_CORNERS)
    ) u_cluster_ram (
        .clk     (clk),
        .wr_en   (clu_wr_en),
        .wr_addr (IDX_W'(cmd_reg.idx)),
        .wr_data (has_room ? clu_appended : clu_merged),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (clu_rdata)
    );

    assign rd_addr   = IDX_W'(q_head.idx);
    assign out_free  = !out_valid_reg || out_ready;
    assign has_room  = (cnt_rdata < COUNT_W'(SLOTS_PER_CLUSTER));
    assign clearing  = (state_reg == BK_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Append into the first free slot
    always_comb
    begin
        clu_appended = clu_rdata;
        clu_appended[cnt_rdata[SLOT_W-1:0]] = cmd_reg.voter;
    end

    // Candidates: the new voter first, then the slots in order
    always_comb
    begin
        cand[0] = cmd_reg.voter;
        for (int k = 0; k < SLOTS_PER_CLUSTER; k++)
        begin
            cand[k+1] = clu_rdata[k];
        end
    end

    // Compare every later candidate against every earlier one
    always_comb
    begin
        for (int a = 0; a < NV; a++)
        begin
            beats[a] = '0;
            for (int b = 0; b < NV; b++)
            begin
                if (b > a)
                begin
                    beats[a][b] = (cand[b].signal < cand[a].signal);
                end
            end
        end
    end

    // Mark the earliest lightest candidate of each prefix and select it
    always_comb
    begin
        for (int m = 0; m < NV; m++)
        begin
            prefix_min[m] = '0;
            for (int i = 0; i < NV; i++)
            begin
                lead[m][i] = (i <= m);
                for (int a = 0; a < NV; a++)
                begin
                    if (a < i)
                    begin
                        lead[m][i] = lead[m][i] && beats[a][i];
                    end
                end
                for (int b = 0; b < NV; b++)
                begin
                    if ((b > i) && (b <= m))
                    begin
                        lead[m][i] = lead[m][i] && !beats[i][b];
                    end
                end
                prefix_min[m] = prefix_min[m] | ({$bits(voter_t){lead[m][i]}} & cand[i]);
            end
        end
    end

    // Carry the new voter through a full cluster: a slot lighter than every
    // earlier candidate takes the lightest of them, the last one is dropped
    always_comb
    begin
        for (int j = 0; j < SLOTS_PER_CLUSTER; j++)
        begin
            clu_merged[j] = lead[j+1][j+1] ? prefix_min[j] : clu_rdata[j];
        end
        carry   = prefix_min[NV-1];
        swapped = !lead[NV-1][0];
    end

    // Pick the voter for a read; slots past the count read as zero
    always_comb
    begin
        if (COUNT_W'(cmd_reg.slot) < cnt_rdata)
        begin
            read_voter = clu_rdata[cmd_reg.slot];
        end
        else
        begin
            read_voter = '0;
        end
    end

    // State and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_word_reg <= out_word_next;
    end

    // Next state, table writes and result
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        cnt_wr_en      = 1'b0;
        cnt_wr_addr    = IDX_W'(cmd_reg.idx);
        cnt_wr_data    = cnt_rdata + 1'b1;
        clu_wr_en      = 1'b0;

        case (state_reg)
            BK_CLEAR:
            begin
                // Zero one count per cycle
                cnt_wr_en   = 1'b1;
                cnt_wr_addr = clr_addr_reg;
                cnt_wr_data = '0;
                if (clr_addr_reg == IDX_W'(MAX_CORNERS - 1))
                begin
                    state_next = BK_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            BK_IDLE:
            begin
                if (q_valid)
                begin
                    if ((q_head.op == CMD_READ) || (q_head.op == CMD_VOTE))
                    begin
                        // Issue the table read, finish in BK_EXEC
                        q_pop      = 1'b1;
                        rd_en      = 1'b1;
                        cmd_next   = q_head;
                        state_next = BK_EXEC;
                    end
                    else if (out_free)
                    begin
                        // Ignored or faulted word: report at once
                        q_pop                       = 1'b1;
                        out_valid_next              = 1'b1;
                        out_word_next               = '0;
                        case (q_head.op)
                            CMD_NONE: out_word_next.status = ST_NONE;
                            CMD_BAD:  out_word_next.status = ST_BAD;
                            default:  out_word_next.status = ST_RANGE;
                        endcase
                    end
                end
            end

            BK_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = '0;
                    state_next     = BK_IDLE;
                    if (cmd_reg.op == CMD_READ)
                    begin
                        out_word_next.status        = ST_READ;
                        out_word_next.cluster_count = cnt_rdata;
                        out_word_next.voter_x       = read_voter.x;
                        out_word_next.voter_y       = read_voter.y;
                        out_word_next.voter_signal  = read_voter.signal;
                    end
                    else if (has_room)
                    begin
                        cnt_wr_en                   = 1'b1;
                        clu_wr_en                   = 1'b1;
                        out_word_next.status        = ST_APPEND;
                        out_word_next.cluster_count = cnt_rdata + 1'b1;
                    end
                    else
                    begin
                        clu_wr_en                    = swapped;
                        out_word_next.status         = swapped ? ST_REPLACE : ST_DROPNEW;
                        out_word_next.cluster_count  = cnt_rdata;
                        out_word_next.dropped_signal = carry.signal;
                    end
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

endmodule
